// ===== rtl/core/free_id_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the free identifier allocator core.
// They expect a clock named clk and an active-low reset named rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FREE_ID_ALLOCATOR_CORE_ASSERT_SVH
`define FREE_ID_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FAC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types and constants of the free identifier allocator core.
// ----------------------------------------------------------------------------
package fac_pkg;

    localparam int ID_W      = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;

    // Reset values of the range registers.
    localparam logic [ID_W-1:0] RANGE_LOW_RESET  = 32'd1000;
    localparam logic [ID_W-1:0] RANGE_HIGH_RESET = 32'd60000;

    // First identifier of the system range.
    localparam logic [ID_W-1:0] SYS_RANGE_FIRST = 32'd1;

    typedef enum logic [1:0] {
        MODE_RECORD    = 2'd0,
        MODE_ALLOC_SYS = 2'd1,
        MODE_ALLOC_REG = 2'd2,
        MODE_PASS      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_GIVEN     = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_RECORDED  = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_SCAN,
        ST_SCAN,
        ST_DECIDE,
        ST_LOAD_MIN,
        ST_MIN,
        ST_FINISH,
        ST_DONE
    } state_t;

    // Value travelling round the ring of cells, with its qualifier.
    typedef struct packed {
        logic            flag;
        logic [ID_W-1:0] value;
    } rot_t;

    // Control shared by every cell of the ring.
    typedef struct packed {
        logic            wr_en;
        logic [ID_W-1:0] wr_data;
        logic            load_scan;
        logic            load_min;
        logic            shift;
        logic            check;
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
    } cell_ctrl_t;

    // Control of the tail accumulator.
    typedef struct packed {
        logic clear;
        logic take_scan;
        logic take_min;
    } tally_ctrl_t;

    // Findings of the tail accumulator.
    typedef struct packed {
        logic            seen;
        logic [ID_W-1:0] top;
        logic            lo_used;
        logic            have;
        logic [ID_W-1:0] best;
    } tally_t;

endpackage

// ===== rtl/core/fac_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_cell
// One cell of the ring: holds one table entry and its successor candidate,
// and passes a rotating value on to the next cell in every cycle that the ring shifts.
// ----------------------------------------------------------------------------
module fac_cell
    import fac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       wr_sel,
    input  logic       in_use,
    input  rot_t       rot_in,
    output rot_t       rot_out
);

    logic [ID_W-1:0] entry_reg;
    logic [ID_W-1:0] entry_next;
    logic [ID_W-1:0] cand_reg;
    logic [ID_W-1:0] cand_next;
    logic            cand_ok_reg;
    logic            cand_ok_next;
    logic [ID_W-1:0] rot_value_reg;
    logic [ID_W-1:0] rot_value_next;
    logic            rot_flag_reg;
    logic            rot_flag_next;

    // Store a recorded identifier when this cell is the next free slot.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.wr_en && wr_sel)
        begin
            entry_next = ctrl.wr_data;
        end
    end

    // The successor of the entry is a candidate when the entry lies in the
    // range below its top; any matching passing entry rules it out.
    always_comb
    begin
        cand_next    = cand_reg;
        cand_ok_next = cand_ok_reg;
        if (ctrl.load_scan)
        begin
            cand_next    = entry_reg + ID_W'(1);
            cand_ok_next = in_use && (entry_reg >= ctrl.lo) && (entry_reg < ctrl.hi);
        end
        else if (ctrl.check && rot_flag_reg && (rot_value_reg == cand_reg))
        begin
            cand_ok_next = 1'b0;
        end
    end

    // Rotating value: the entry during the scan, the candidate during the
    // minimum search, otherwise whatever the previous cell hands on.
    always_comb
    begin
        rot_value_next = rot_value_reg;
        rot_flag_next  = rot_flag_reg;
        if (ctrl.load_scan)
        begin
            rot_value_next = entry_reg;
            rot_flag_next  = in_use;
        end
        else if (ctrl.load_min)
        begin
            rot_value_next = cand_reg;
            rot_flag_next  = cand_ok_reg;
        end
        else if (ctrl.shift)
        begin
            rot_value_next = rot_in.value;
            rot_flag_next  = rot_in.flag;
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_ok_reg  <= 1'b0;
            rot_flag_reg <= 1'b0;
        end
        else
        begin
            cand_ok_reg  <= cand_ok_next;
            rot_flag_reg <= rot_flag_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        entry_reg     <= entry_next;
        cand_reg      <= cand_next;
        rot_value_reg <= rot_value_next;
    end

    assign rot_out.flag  = rot_flag_reg;
    assign rot_out.value = rot_value_reg;

endmodule

// ===== rtl/core/fac_tally.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_tally
// Accumulator at the tail of the ring: gathers the highest used identifier
// in range, whether the range start is used, and the lowest free candidate.
// ----------------------------------------------------------------------------
module fac_tally
    import fac_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  tally_ctrl_t     ctrl,
    input  logic [ID_W-1:0] lo,
    input  logic [ID_W-1:0] hi,
    input  rot_t            tail,
    output tally_t          result
);

    logic            seen_reg;
    logic            seen_next;
    logic [ID_W-1:0] top_reg;
    logic [ID_W-1:0] top_next;
    logic            lo_used_reg;
    logic            lo_used_next;
    logic            have_reg;
    logic            have_next;
    logic [ID_W-1:0] best_reg;
    logic [ID_W-1:0] best_next;

    // Take one value from the tail of the ring per cycle while a scan or minimum search is running.
    always_comb
    begin
        seen_next    = seen_reg;
        top_next     = top_reg;
        lo_used_next = lo_used_reg;
        have_next    = have_reg;
        best_next    = best_reg;
        if (ctrl.clear)
        begin
            seen_next    = 1'b0;
            lo_used_next = 1'b0;
            have_next    = 1'b0;
        end
        else if (ctrl.take_scan && tail.flag)
        begin
            if ((tail.value >= lo) && (tail.value <= hi) &&
                (!seen_reg || (tail.value > top_reg)))
            begin
                seen_next = 1'b1;
                top_next  = tail.value;
            end
            if (tail.value == lo)
            begin
                lo_used_next = 1'b1;
            end
        end
        else if (ctrl.take_min && tail.flag)
        begin
            if (!have_reg || (tail.value < best_reg))
            begin
                have_next = 1'b1;
                best_next = tail.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 1'b0;
            lo_used_reg <= 1'b0;
            have_reg    <= 1'b0;
        end
        else
        begin
            seen_reg    <= seen_next;
            lo_used_reg <= lo_used_next;
            have_reg    <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        best_reg <= best_next;
    end

    assign result.seen    = seen_reg;
    assign result.top     = top_reg;
    assign result.lo_used = lo_used_reg;
    assign result.have    = have_reg;
    assign result.best    = best_reg;

endmodule

// ===== rtl/core/free_id_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_id_allocator_core
// Keeps a table of used identifiers in a ring of cells and hands out the
// next free identifier of the system or the regular range.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_*      in         tuser: mode; tdata: ident
//  m_*      out        tuser: status; tdata: result_ident
//  cfg_*    in         range_low (index 0), range_high (index 1)
//
//  Record and pass-through transfers: the result goes through the pending
//  result register into the output register; the next input transfer waits
//  until the sequencer is back in idle. Allocation: ends after the first
//  rotation of the cell ring (duplicate check) when that settles the answer,
//  else after two full rotations (duplicate check, then minimum search).
//  One item is in work at a time; a finished result waits while the output
//  register holds an untaken one, and the output register frees the input
//  side as soon as a result has moved into it.
//  Reset clears the entry count and reloads the range registers; table
//  entries need no clearing.
// ----------------------------------------------------------------------------
`include "free_id_allocator_core_assert.svh"

module free_id_allocator_core
    import fac_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ID_W-1:0]      s_tdata,   // [31:0] ident
    input  logic [1:0]           s_tuser,   // [1:0] mode
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ID_W-1:0]      m_tdata,   // [31:0] result_ident
    output logic [1:0]           m_tuser,   // [1:0] status
    // Configuration writes
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_wdata
);

    localparam int CNT_W   = $clog2(TABLE_DEPTH);
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [COUNT_W-1:0]   used_count_reg;
    logic [COUNT_W-1:0]   used_count_next;
    logic [ID_W-1:0]      range_low_reg;
    logic [ID_W-1:0]      range_high_reg;
    logic [ID_W-1:0]      lo_reg;
    logic [ID_W-1:0]      lo_next;
    logic [ID_W-1:0]      hi_reg;
    logic [ID_W-1:0]      hi_next;
    logic [ID_W-1:0]      res_ident_reg;
    logic [ID_W-1:0]      res_ident_next;
    status_t              res_status_reg;
    status_t              res_status_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [ID_W-1:0]      m_ident_reg;
    logic [ID_W-1:0]      m_ident_next;
    status_t              m_status_reg;
    status_t              m_status_next;

    mode_t                in_mode;
    logic                 s_accept;
    logic                 is_alloc;
    logic                 room;
    logic [ID_W-1:0]      alloc_lo;
    logic [ID_W-1:0]      alloc_hi;
    logic                 range_empty;
    logic                 cnt_last;
    logic                 decide_top;
    logic                 out_load;

    cell_ctrl_t           cell_ctrl;
    tally_ctrl_t          tally_ctrl;
    tally_t               tally;
    logic [TABLE_DEPTH-1:0] wr_sel;
    logic [TABLE_DEPTH-1:0] in_use;
    rot_t                 rot_chain [TABLE_DEPTH];

    // Input decode.
    assign in_mode     = mode_t'(s_tuser);
    assign s_accept    = s_tvalid && s_tready;
    assign is_alloc    = (in_mode == MODE_ALLOC_SYS) || (in_mode == MODE_ALLOC_REG);
    assign room        = (used_count_reg < COUNT_W'(TABLE_DEPTH));
    assign alloc_lo    = (in_mode == MODE_ALLOC_SYS) ? SYS_RANGE_FIRST : range_low_reg;
    assign alloc_hi    = (in_mode == MODE_ALLOC_SYS) ? (range_low_reg - ID_W'(1))
                                                     : range_high_reg;
    assign range_empty = (alloc_lo > alloc_hi);
    assign cnt_last    = (cnt_reg == CNT_W'(TABLE_DEPTH - 1));
    assign decide_top  = tally.seen && (tally.top < hi_reg);
    assign out_load    = !m_tvalid_reg || m_tready;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RESET;
            range_high_reg <= RANGE_HIGH_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_RANGE_LOW:  range_low_reg  <= cfg_wdata;
                REG_RANGE_HIGH: range_high_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = (is_alloc && !range_empty) ? ST_LOAD_SCAN : ST_DONE;
                end
            end
            ST_LOAD_SCAN: state_next = ST_SCAN;
            ST_SCAN:      state_next = cnt_last ? ST_DECIDE : ST_SCAN;
            ST_DECIDE:    state_next = (decide_top || !tally.lo_used) ? ST_DONE : ST_LOAD_MIN;
            ST_LOAD_MIN:  state_next = ST_MIN;
            ST_MIN:       state_next = cnt_last ? ST_FINISH : ST_MIN;
            ST_FINISH:    state_next = ST_DONE;
            ST_DONE:      state_next = out_load ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs to the ring and the accumulator.
    always_comb
    begin
        s_tready             = 1'b0;
        cell_ctrl.wr_en      = 1'b0;
        cell_ctrl.wr_data    = s_tdata;
        cell_ctrl.load_scan  = 1'b0;
        cell_ctrl.load_min   = 1'b0;
        cell_ctrl.shift      = 1'b0;
        cell_ctrl.check      = 1'b0;
        cell_ctrl.lo         = lo_reg;
        cell_ctrl.hi         = hi_reg;
        tally_ctrl.clear     = 1'b0;
        tally_ctrl.take_scan = 1'b0;
        tally_ctrl.take_min  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready        = 1'b1;
                cell_ctrl.wr_en = s_tvalid && (in_mode == MODE_RECORD);
            end
            ST_LOAD_SCAN:
            begin
                cell_ctrl.load_scan = 1'b1;
                tally_ctrl.clear    = 1'b1;
            end
            ST_SCAN:
            begin
                cell_ctrl.shift      = 1'b1;
                cell_ctrl.check      = 1'b1;
                tally_ctrl.take_scan = 1'b1;
            end
            ST_LOAD_MIN:
            begin
                cell_ctrl.load_min = 1'b1;
            end
            ST_MIN:
            begin
                cell_ctrl.shift     = 1'b1;
                tally_ctrl.take_min = 1'b1;
            end
            default: ;
        endcase
    end

    // Step counter for the ring rotations.
    assign cnt_next = ((state_reg == ST_SCAN) || (state_reg == ST_MIN)) ?
                      (cnt_reg + CNT_W'(1)) : '0;

    // Entry count, range bounds and the pending result.
    always_comb
    begin
        used_count_next = used_count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_ident_next  = res_ident_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    lo_next         = alloc_lo;
                    hi_next         = alloc_hi;
                    res_ident_next  = '0;
                    res_status_next = STATUS_EXHAUSTED;
                    case (in_mode)
                        MODE_RECORD:
                        begin
                            if (room)
                            begin
                                used_count_next = used_count_reg + COUNT_W'(1);
                                res_status_next = STATUS_RECORDED;
                            end
                            else
                            begin
                                res_status_next = STATUS_FULL;
                            end
                        end
                        MODE_PASS:
                        begin
                            res_ident_next  = s_tdata;
                            res_status_next = STATUS_GIVEN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DECIDE:
            begin
                if (decide_top)
                begin
                    res_ident_next  = tally.top + ID_W'(1);
                    res_status_next = STATUS_GIVEN;
                end
                else if (!tally.lo_used)
                begin
                    res_ident_next  = lo_reg;
                    res_status_next = STATUS_GIVEN;
                end
            end
            ST_FINISH:
            begin
                if (tally.have)
                begin
                    res_ident_next  = tally.best;
                    res_status_next = STATUS_GIVEN;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_ident_next  = m_ident_reg;
        m_status_next = m_status_reg;
        if ((state_reg == ST_DONE) && out_load)
        begin
            m_tvalid_next = 1'b1;
            m_ident_next  = res_ident_reg;
            m_status_next = res_status_reg;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            used_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            used_count_reg <= used_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_ident_reg  <= res_ident_next;
        res_status_reg <= res_status_next;
        m_ident_reg    <= m_ident_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_ident_reg;
    assign m_tuser  = m_status_reg;

    // Ring of cells; the last cell feeds the first and the accumulator.
    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        assign wr_sel[k] = (used_count_reg == COUNT_W'(k));
        assign in_use[k] = (used_count_reg > COUNT_W'(k));

        fac_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .wr_sel  (wr_sel[k]),
            .in_use  (in_use[k]),
            .rot_in  (rot_chain[(k + TABLE_DEPTH - 1) % TABLE_DEPTH]),
            .rot_out (rot_chain[k])
        );
    end

    fac_tally u_tally (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (tally_ctrl),
        .lo     (lo_reg),
        .hi     (hi_reg),
        .tail   (rot_chain[TABLE_DEPTH-1]),
        .result (tally)
    );

    // Checks.
    `FAC_ASSERT_IMP(a_count_bound, 1'b1, used_count_reg <= COUNT_W'(TABLE_DEPTH),
                    "entry count beyond table depth")
    `FAC_ASSERT_NXT(a_record_count, s_accept && (in_mode == MODE_RECORD) && room,
                    used_count_reg == $past(used_count_reg) + COUNT_W'(1),
                    "record transfer did not grow the table")
    `FAC_ASSERT_NXT(a_count_held, state_reg != ST_IDLE,
                    used_count_reg == $past(used_count_reg),
                    "table changed while an item was in work")
    `FAC_ASSERT_IMP(a_zero_ident, m_tvalid && (m_tuser != STATUS_GIVEN), m_tdata == '0,
                    "non-zero identifier with a failure or record status")

endmodule

// ===== sim/free_id_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_id_allocator_core_tb
// Self-checking bench for the free identifier allocator. Requests are fed
// through the input stream with random gaps. Results are taken from the
// output stream with random back-pressure. A scoreboard keeps its own copy
// of the used-identifier table and of the two range registers, works out
// each answer and compares it field by field with the block's result.
// ----------------------------------------------------------------------------
module free_id_allocator_core_tb;
    import fac_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int STALL_LIMIT = 2000;

    // Register indexes that the block decodes to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0] ident;
        status_t         status;
    } answer_t;

    // Scoreboard: tracks the used identifiers and the ranges, and holds the
    // answers still owed by the block, oldest first.
    class alloc_checker;
        logic [ID_W-1:0] taken[TABLE_DEPTH];
        int              taken_count;
        logic [ID_W-1:0] low_bound;
        logic [ID_W-1:0] high_bound;
        answer_t         answers[$];
        int              mismatches;

        function new();
            taken_count = 0;
            low_bound   = RANGE_LOW_RESET;
            high_bound  = RANGE_HIGH_RESET;
            mismatches  = 0;
        endfunction

        task report(string what);
            $display("%0t ns: MISMATCH: %s", $time, what);
            mismatches++;
        endtask

        function bit is_taken(logic [ID_W-1:0] v);
            for (int i = 0; i < taken_count; i++)
            begin
                if (taken[i] == v)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Next free identifier within [lo, hi]: one above the highest used
        // value if that still fits, or else the lowest unused value.
        function bit first_free(logic [ID_W-1:0] lo, logic [ID_W-1:0] hi,
                                output logic [ID_W-1:0] got);
            logic [ID_W-1:0] top;
            logic [ID_W-1:0] best;
            logic [ID_W-1:0] u;
            logic [ID_W-1:0] cand;
            bit              seen;
            bit              have;
            got  = '0;
            top  = '0;
            best = '0;
            seen = 1'b0;
            have = 1'b0;
            if (lo > hi)
                return 1'b0;
            for (int i = 0; i < taken_count; i++)
            begin
                u = taken[i];
                if (u >= lo && u <= hi && (!seen || u > top))
                begin
                    top  = u;
                    seen = 1'b1;
                end
            end
            if (seen && top < hi)
            begin
                got = top + 32'd1;
                return 1'b1;
            end
            if (!is_taken(lo))
            begin
                got = lo;
                return 1'b1;
            end
            // The lowest gap lies just above some used identifier.
            for (int i = 0; i < taken_count; i++)
            begin
                u = taken[i];
                if (u >= lo && u < hi)
                begin
                    cand = u + 32'd1;
                    if ((!have || cand < best) && !is_taken(cand))
                    begin
                        best = cand;
                        have = 1'b1;
                    end
                end
            end
            got = best;
            return have;
        endfunction

        function void write_range(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
            case (idx)
                REG_RANGE_LOW:  low_bound  = data;
                REG_RANGE_HIGH: high_bound = data;
                default: ;
            endcase
        endfunction

        function void note_request(logic [1:0] mode, logic [ID_W-1:0] ident);
            answer_t         a;
            logic [ID_W-1:0] got;
            a.ident  = '0;
            a.status = STATUS_GIVEN;
            case (mode_t'(mode))
                MODE_RECORD:
                begin
                    if (taken_count < TABLE_DEPTH)
                    begin
                        taken[taken_count] = ident;
                        taken_count++;
                        a.status = STATUS_RECORDED;
                    end
                    else
                        a.status = STATUS_FULL;
                end
                MODE_ALLOC_SYS:
                begin
                    if (first_free(SYS_RANGE_FIRST, low_bound - 32'd1, got))
                        a.ident = got;
                    else
                        a.status = STATUS_EXHAUSTED;
                end
                MODE_ALLOC_REG:
                begin
                    if (first_free(low_bound, high_bound, got))
                        a.ident = got;
                    else
                        a.status = STATUS_EXHAUSTED;
                end
                default:
                    a.ident = ident;
            endcase
            answers.push_back(a);
        endfunction

        task check_answer(logic [ID_W-1:0] ident, logic [1:0] status);
            answer_t a;
            if (answers.size() == 0)
                report($sformatf("result %0h / status %0d with nothing expected",
                                 ident, status));
            else
            begin
                a = answers.pop_front();
                if (ident !== a.ident)
                    report($sformatf("result_ident %0h, expected %0h", ident, a.ident));
                if (status !== a.status)
                    report($sformatf("status %0d, expected %0d", status, a.status));
            end
        endtask

        task close();
            while (answers.size() != 0)
            begin
                report("expected result never arrived");
                void'(answers.pop_front());
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [ID_W-1:0]      s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [ID_W-1:0]      m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ID_W-1:0]      cfg_wdata;

    alloc_checker sb = new();
    bit           steady;
    int           stall_cycles;

    free_id_allocator_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Idle length: mostly none or short, now and then long; none at all
    // during steady phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Monitor: results are checked before the request of the same edge is
    // noted, so the queue order always matches the block's order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_answer(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata);
            if (cfg_wen)
                sb.write_range(cfg_index, cfg_wdata);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("free_id_allocator_core_tb NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Result side: random back-pressure, one transfer per ready window.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Offers one request and waits for its transfer, after a random gap.
    task automatic send_item(mode_t mode, logic [ID_W-1:0] ident);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = ident;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_wen   = 1'b0;
    endtask

    // Withdraws the last request, waits until every owed result has
    // arrived, then lets the block settle.
    task automatic settle(int extra);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.answers.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_ranges(logic [ID_W-1:0] lo, logic [ID_W-1:0] hi);
        settle(8);
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_RANGE_LOW, lo);
            write_reg(REG_RANGE_HIGH, hi);
        end
        else
        begin
            write_reg(REG_RANGE_HIGH, hi);
            write_reg(REG_RANGE_LOW, lo);
        end
    endtask

    // Main sequence: reset, directed requests, then random phases.
    initial
    begin
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
        logic [ID_W-1:0] ident;
        int              r;
        int              rec_pct;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_RECORD;
        cfg_wen   = 1'b0;
        cfg_index = REG_RANGE_LOW;
        cfg_wdata = '0;
        steady    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Pass-through extremes, then allocation from an empty table.
        send_item(MODE_PASS, 32'h0000_0000);
        send_item(MODE_PASS, 32'hFFFF_FFFF);
        send_item(MODE_ALLOC_SYS, $urandom);
        send_item(MODE_ALLOC_REG, $urandom);
        // Successor of the highest used value, then wrap to the lowest gap
        // once the top of the range is used.
        send_item(MODE_RECORD, 32'd1);
        send_item(MODE_RECORD, 32'd2);
        send_item(MODE_RECORD, 32'd3);
        send_item(MODE_ALLOC_SYS, $urandom);
        send_item(MODE_RECORD, 32'd999);
        send_item(MODE_ALLOC_SYS, $urandom);
        send_item(MODE_RECORD, 32'd60000);
        send_item(MODE_ALLOC_REG, $urandom);
        send_item(MODE_RECORD, 32'd1000);
        send_item(MODE_ALLOC_REG, $urandom);
        // A duplicate record and identifiers outside both ranges.
        send_item(MODE_RECORD, 32'd5);
        send_item(MODE_RECORD, 32'd6);
        send_item(MODE_RECORD, 32'd7);
        send_item(MODE_RECORD, 32'd6);
        send_item(MODE_RECORD, 32'h0000_0000);
        send_item(MODE_RECORD, 32'hFFFF_FFFF);

        // Fully used regular range; writes to unused indexes are ignored.
        set_ranges(32'd5, 32'd7);
        write_reg(REG_SPARE_2, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_3, 32'h0000_0001);
        send_item(MODE_ALLOC_REG, $urandom);
        send_item(MODE_ALLOC_SYS, $urandom);
        // Empty system range.
        set_ranges(32'd1, 32'd60000);
        send_item(MODE_ALLOC_SYS, $urandom);
        // Zero low bound: the system range wraps to the top of the space.
        set_ranges(32'd0, 32'd7);
        send_item(MODE_ALLOC_SYS, $urandom);
        // Low bound above high bound.
        set_ranges(32'hFFFF_FFFF, 32'd1);
        send_item(MODE_ALLOC_REG, $urandom);

        // Random phases, each under its own pair of ranges. Records are
        // frequent early so that the table fills, rare afterwards.
        for (int phase = 0; phase < 16; phase++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    lo = $urandom_range(1, 48);
                    hi = lo + $urandom_range(0, 6);
                end
                1:
                begin
                    lo = $urandom_range(2, 2000);
                    hi = $urandom_range(lo, 70000);
                end
                2:
                begin
                    r  = $urandom_range(0, 2);
                    lo = (r == 0) ? 32'd0 : (r == 1) ? 32'd1 : 32'hFFFF_FFFF;
                    r  = $urandom_range(0, 2);
                    hi = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
                end
                default:
                begin
                    lo = $urandom;
                    hi = $urandom;
                end
            endcase
            set_ranges(lo, hi);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
            steady  = (phase % 4 == 3);
            rec_pct = (phase < 2) ? 35 : 5;

            for (int n = 0; n < 100; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < rec_pct)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        ident = $urandom_range(1, 48);
                    else if (r < 85)
                        ident = 32'hFFFF_FFC0 + $urandom_range(0, 63);
                    else
                        ident = $urandom;
                    send_item(MODE_RECORD, ident);
                end
                else if (r < 90)
                    send_item($urandom_range(0, 1) ? MODE_ALLOC_SYS : MODE_ALLOC_REG,
                              $urandom);
                else
                    send_item(MODE_PASS, $urandom);
            end
        end

        // Drain, then watch for stray results a little longer.
        steady = 1'b0;
        settle(3 * TABLE_DEPTH);
        sb.close();
        if (sb.mismatches == 0)
            $display("free_id_allocator_core_tb OK");
        else
            $display("free_id_allocator_core_tb NOT OK");
        $finish;
    end

endmodule

// ===== free_id_allocator_core.f =====
+incdir+rtl/core
rtl/core/fac_pkg.sv
rtl/core/fac_cell.sv
rtl/core/fac_tally.sv
rtl/core/free_id_allocator_core.sv
sim/free_id_allocator_core_tb.sv
